>>> rtl/tsfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared face match package
// Types and constants used across the shared face match block.
// ----------------------------------------------------------------------------
package tsfm_pkg;

  localparam int unsigned NODES = 4;
  localparam int unsigned ID_W  = 31;
  localparam int unsigned OUT_W = 32;

  localparam logic [OUT_W-1:0] NO_ID = '1;

  typedef logic [ID_W-1:0]   id_t;
  typedef id_t [NODES-1:0]   id_vec_t;
  typedef logic [NODES-1:0]  match_t;

  typedef struct packed {
    logic                    found;
    logic signed [OUT_W-1:0] low;
    logic signed [OUT_W-1:0] mid;
    logic signed [OUT_W-1:0] high;
  } face_t;

endpackage
`default_nettype wire

>>> rtl/tsfm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared face match channels
// Request channel carrying two tetrahedra and result channel carrying a face.
// ----------------------------------------------------------------------------
interface tsfm_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] tet_a_node_0;
  logic [30:0] tet_a_node_1;
  logic [30:0] tet_a_node_2;
  logic [30:0] tet_a_node_3;
  logic [30:0] tet_b_node_0;
  logic [30:0] tet_b_node_1;
  logic [30:0] tet_b_node_2;
  logic [30:0] tet_b_node_3;

  modport source (
    output valid, tet_a_node_0, tet_a_node_1, tet_a_node_2, tet_a_node_3,
           tet_b_node_0, tet_b_node_1, tet_b_node_2, tet_b_node_3,
    input  ready
  );
  modport sink (
    input  valid, tet_a_node_0, tet_a_node_1, tet_a_node_2, tet_a_node_3,
           tet_b_node_0, tet_b_node_1, tet_b_node_2, tet_b_node_3,
    output ready
  );
endinterface

interface tsfm_out_if;
  logic               valid;
  logic               ready;
  logic               face_found;
  logic signed [31:0] face_id_low;
  logic signed [31:0] face_id_mid;
  logic signed [31:0] face_id_high;

  modport source (
    output valid, face_found, face_id_low, face_id_mid, face_id_high,
    input  ready
  );
  modport sink (
    input  valid, face_found, face_id_low, face_id_mid, face_id_high,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/tsfm_sort4.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-id sorter
// Five-comparator network that orders four vertex ids ascending.
// ----------------------------------------------------------------------------
module tsfm_sort4
  import tsfm_pkg::*;
(
  input  id_vec_t ids_i,
  output id_vec_t sorted_o
);

  id_vec_t l1;
  id_vec_t l2;

  always_comb begin
    l1 = ids_i;
    if (ids_i[0] > ids_i[1]) begin
      l1[0] = ids_i[1];
      l1[1] = ids_i[0];
    end
    if (ids_i[2] > ids_i[3]) begin
      l1[2] = ids_i[3];
      l1[3] = ids_i[2];
    end
  end

  always_comb begin
    l2 = l1;
    if (l1[0] > l1[2]) begin
      l2[0] = l1[2];
      l2[2] = l1[0];
    end
    if (l1[1] > l1[3]) begin
      l2[1] = l1[3];
      l2[3] = l1[1];
    end
  end

  always_comb begin
    sorted_o = l2;
    if (l2[1] > l2[2]) begin
      sorted_o[1] = l2[2];
      sorted_o[2] = l2[1];
    end
  end

endmodule
`default_nettype wire

>>> rtl/tsfm_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Match lane
// Decides whether one sorted id of tetrahedron A pairs with an id of B.
// An id pairs when its rank among equal ids of A is below their count in B.
// ----------------------------------------------------------------------------
module tsfm_lane
  import tsfm_pkg::*;
(
  input  logic [1:0] lane_idx_i,
  input  id_vec_t    a_i,
  input  id_vec_t    b_i,
  output logic       match_o
);

  id_t        id;
  logic [1:0] rank;
  logic [2:0] cnt;

  assign id = a_i[lane_idx_i];

  always_comb begin
    rank = '0;
    cnt  = '0;
    for (int k = 0; k < NODES; k++) begin
      if ((2'(k) < lane_idx_i) && (a_i[k] == id)) begin
        rank = rank + 2'd1;
      end
      if (b_i[k] == id) begin
        cnt = cnt + 3'd1;
      end
    end
  end

  assign match_o = ({1'b0, rank} < cnt);

endmodule
`default_nettype wire

>>> rtl/tsfm_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lane merge
// Combines the lane match flags into the found flag and three face ids.
// ----------------------------------------------------------------------------
module tsfm_merge
  import tsfm_pkg::*;
(
  input  id_vec_t a_i,
  input  match_t  match_i,
  output face_t   face_o
);

  logic [2:0] hits;

  always_comb begin
    hits = '0;
    for (int k = 0; k < NODES; k++) begin
      hits = hits + {2'b00, match_i[k]};
    end
  end

  always_comb begin
    face_o.found = 1'b0;
    face_o.low   = NO_ID;
    face_o.mid   = NO_ID;
    face_o.high  = NO_ID;
    if (hits >= 3'd3) begin
      face_o.found = 1'b1;
      if (!match_i[0]) begin
        face_o.low  = {1'b0, a_i[1]};
        face_o.mid  = {1'b0, a_i[2]};
        face_o.high = {1'b0, a_i[3]};
      end else if (!match_i[1]) begin
        face_o.low  = {1'b0, a_i[0]};
        face_o.mid  = {1'b0, a_i[2]};
        face_o.high = {1'b0, a_i[3]};
      end else if (!match_i[2]) begin
        face_o.low  = {1'b0, a_i[0]};
        face_o.mid  = {1'b0, a_i[1]};
        face_o.high = {1'b0, a_i[3]};
      end else begin
        face_o.low  = {1'b0, a_i[0]};
        face_o.mid  = {1'b0, a_i[1]};
        face_o.high = {1'b0, a_i[2]};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/tetra_shared_face_match.sv
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted request is driven straight from the merge stage register.
// Throughput: one request per cycle; the three-stage pipeline (sort, lanes,
// merge) holds a request in each stage and stalls only on output back-pressure.
// Reset: all stage valid flags clear asynchronously; no request is pending.
// ----------------------------------------------------------------------------
// Tetrahedron shared face match
// Sorts the ids of two tetrahedra, matches them in four lanes and reports
// the shared triangular face, if any.
// ----------------------------------------------------------------------------
module tetra_shared_face_match
  import tsfm_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  tsfm_in_if.sink      in_i,
  tsfm_out_if.source   out_o
);

  id_vec_t a_raw;
  id_vec_t b_raw;
  id_vec_t a_srt;
  id_vec_t b_srt;

  logic    s1_valid_q;
  id_vec_t s1_a_q;
  id_vec_t s1_b_q;
  logic    s2_valid_q;
  id_vec_t s2_a_q;
  match_t  s2_match_q;
  match_t  match_d;
  logic    s3_valid_q;
  face_t   face_d;
  face_t   face_q;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  assign a_raw = {in_i.tet_a_node_3, in_i.tet_a_node_2, in_i.tet_a_node_1, in_i.tet_a_node_0};
  assign b_raw = {in_i.tet_b_node_3, in_i.tet_b_node_2, in_i.tet_b_node_1, in_i.tet_b_node_0};

  tsfm_sort4 u_sort_a (.ids_i(a_raw), .sorted_o(a_srt));
  tsfm_sort4 u_sort_b (.ids_i(b_raw), .sorted_o(b_srt));

  for (genvar g = 0; g < NODES; g++) begin : g_lane
    tsfm_lane u_lane (
      .lane_idx_i(2'(g)),
      .a_i       (s1_a_q),
      .b_i       (s1_b_q),
      .match_o   (match_d[g])
    );
  end

  tsfm_merge u_merge (.a_i(s2_a_q), .match_i(s2_match_q), .face_o(face_d));

  assign s3_ready  = !s3_valid_q || out_o.ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_a_q <= a_srt;
      s1_b_q <= b_srt;
    end
    if (s2_ready && s1_valid_q) begin
      s2_a_q     <= s1_a_q;
      s2_match_q <= match_d;
    end
    if (s3_ready && s2_valid_q) begin
      face_q <= face_d;
    end
  end

  assign out_o.valid        = s3_valid_q;
  assign out_o.face_found   = face_q.found;
  assign out_o.face_id_low  = face_q.low;
  assign out_o.face_id_mid  = face_q.mid;
  assign out_o.face_id_high = face_q.high;

  // A result without a face carries all ones in every id slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !face_q.found) |->
      (face_q.low == NO_ID && face_q.mid == NO_ID && face_q.high == NO_ID))
    else $error("missing face not reported as all ones");

  // A found face lists non-negative ids in ascending order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && face_q.found) |->
      (!face_q.low[OUT_W-1] && face_q.low <= face_q.mid && face_q.mid <= face_q.high))
    else $error("face ids out of order");

  // An accepted request always occupies the first stage afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted request lost in the sort stage");

endmodule
`default_nettype wire
